// ----- design/pbfp_pkg.sv -----
// Shared types and constants of the protobuf field parser.
package pbfp_pkg;

    localparam int POS_BITS        = 32;
    localparam int OFFSET_BITS     = 32;
    localparam int FNUM_BITS       = 32;
    localparam int VALUE_BITS      = 64;
    localparam int WTYPE_BITS      = 3;
    localparam int CNT_BITS        = 4;
    localparam int M_TDATA_BITS    = 136;

    localparam logic [CNT_BITS-1:0] VARINT_MAX_BYTES = 4'd10;
    localparam logic [CNT_BITS-1:0] FIX64_BYTES      = 4'd8;
    localparam logic [CNT_BITS-1:0] FIX32_BYTES      = 4'd4;

    // result kinds
    localparam logic [1:0] RK_FIELD = 2'd0;
    localparam logic [1:0] RK_END   = 2'd1;
    localparam logic [1:0] RK_ERROR = 2'd2;

    // error codes
    localparam logic [1:0] ERR_VARINT   = 2'd0;
    localparam logic [1:0] ERR_END      = 2'd1;
    localparam logic [1:0] ERR_WTYPE    = 2'd2;
    localparam logic [1:0] ERR_ZERO_FLD = 2'd3;

    // wire types
    localparam logic [WTYPE_BITS-1:0] WT_VARINT = 3'd0;
    localparam logic [WTYPE_BITS-1:0] WT_FIX64  = 3'd1;
    localparam logic [WTYPE_BITS-1:0] WT_LEN    = 3'd2;
    localparam logic [WTYPE_BITS-1:0] WT_FIX32  = 3'd5;

    typedef struct packed {
        logic [1:0]            kind;
        logic [FNUM_BITS-1:0]  field_number;
        logic [WTYPE_BITS-1:0] wire_type;
        logic [VALUE_BITS-1:0] field_value;
        logic [OFFSET_BITS-1:0] payload_offset;
        logic [1:0]            error_code;
    } pbfp_result_t;

endpackage

// ----- design/pbfp_decoder.sv -----
// Wire-format decode state and the per-byte next-state logic.
module pbfp_decoder (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic                 item_kind,
    input  logic [7:0]           in_byte,
    output logic                 res_valid,
    output pbfp_pkg::pbfp_result_t res
);
    import pbfp_pkg::*;

    localparam logic [2:0] PH_TAG     = 3'd0;
    localparam logic [2:0] PH_VARINT  = 3'd1;
    localparam logic [2:0] PH_FIX64   = 3'd2;
    localparam logic [2:0] PH_FIX32   = 3'd3;
    localparam logic [2:0] PH_LEN     = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_DRAIN   = 3'd6;

    logic [2:0]             phase_reg, phase_next;
    logic [VALUE_BITS-1:0]  acc_reg, acc_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [FNUM_BITS-1:0]   fnum_reg, fnum_next;
    logic [WTYPE_BITS-1:0]  wtype_reg, wtype_next;
    logic [VALUE_BITS-1:0]  rem_reg, rem_next;
    logic [POS_BITS-1:0]    pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] pstart_reg, pstart_next;

    // varint byte merge
    logic [6:0]             v_shift;
    logic                   v_room;
    logic [VALUE_BITS-1:0]  v_acc;
    logic [CNT_BITS-1:0]    v_cnt;
    logic                   v_done, v_over;
    // fixed byte merge
    logic [VALUE_BITS-1:0]  f_acc;
    logic [CNT_BITS-1:0]    f_cnt;
    logic [FNUM_BITS-1:0]   tag_fnum;
    logic [WTYPE_BITS-1:0]  tag_wtype;

    always_comb begin
        v_shift   = {cnt_reg, 3'b000} - {3'b000, cnt_reg};
        v_room    = cnt_reg < VARINT_MAX_BYTES;
        v_acc     = v_room ? (acc_reg | (VALUE_BITS'(in_byte[6:0]) << v_shift)) : acc_reg;
        v_cnt     = v_room ? cnt_reg + 1'b1 : cnt_reg;
        v_done    = !in_byte[7];
        v_over    = in_byte[7] && (v_cnt >= VARINT_MAX_BYTES);
        f_acc     = acc_reg | (VALUE_BITS'(in_byte) << {cnt_reg[2:0], 3'b000});
        f_cnt     = cnt_reg + 1'b1;
        tag_fnum  = v_acc[FNUM_BITS+2:3];
        tag_wtype = v_acc[2:0];
    end

    always_comb begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        fnum_next   = fnum_reg;
        wtype_next  = wtype_reg;
        rem_next    = rem_reg;
        pos_next    = pos_reg;
        pstart_next = pstart_reg;
        res_valid   = 1'b0;
        res         = '0;

        if (item_kind) begin
            // end of buffer: back to the reset state
            phase_next  = PH_TAG;
            acc_next    = '0;
            cnt_next    = '0;
            fnum_next   = '0;
            wtype_next  = '0;
            rem_next    = '0;
            pos_next    = '0;
            pstart_next = '0;
            case (phase_reg)
                PH_DRAIN: res_valid = 1'b0;
                PH_TAG: begin
                    res_valid = 1'b1;
                    res.kind  = (cnt_reg == '0) ? RK_END : RK_ERROR;
                end
                PH_VARINT, PH_LEN: begin
                    res_valid      = 1'b1;
                    res.kind       = RK_ERROR;
                    res.error_code = ERR_VARINT;
                end
                default: begin
                    res_valid      = 1'b1;
                    res.kind       = RK_ERROR;
                    res.error_code = ERR_END;
                end
            endcase
        end else begin
            pos_next = pos_reg + 1'b1;
            res.field_number = fnum_reg;
            res.wire_type    = wtype_reg;
            case (phase_reg)
                PH_TAG: begin
                    acc_next = v_acc;
                    cnt_next = v_cnt;
                    if (v_over) begin
                        phase_next     = PH_DRAIN;
                        res_valid      = 1'b1;
                        res            = '0;
                        res.kind       = RK_ERROR;
                        res.error_code = ERR_VARINT;
                    end else if (v_done) begin
                        acc_next   = '0;
                        cnt_next   = '0;
                        fnum_next  = tag_fnum;
                        wtype_next = tag_wtype;
                        res        = '0;
                        res.kind   = RK_ERROR;
                        if (tag_fnum == '0) begin
                            phase_next     = PH_DRAIN;
                            res_valid      = 1'b1;
                            res.error_code = ERR_ZERO_FLD;
                        end else begin
                            case (tag_wtype)
                                WT_VARINT: phase_next = PH_VARINT;
                                WT_FIX64:  phase_next = PH_FIX64;
                                WT_LEN:    phase_next = PH_LEN;
                                WT_FIX32:  phase_next = PH_FIX32;
                                default: begin
                                    phase_next     = PH_DRAIN;
                                    res_valid      = 1'b1;
                                    res.error_code = ERR_WTYPE;
                                end
                            endcase
                        end
                    end
                end
                PH_VARINT: begin
                    acc_next = v_acc;
                    cnt_next = v_cnt;
                    if (v_over) begin
                        phase_next     = PH_DRAIN;
                        res_valid      = 1'b1;
                        res            = '0;
                        res.kind       = RK_ERROR;
                        res.error_code = ERR_VARINT;
                    end else if (v_done) begin
                        phase_next      = PH_TAG;
                        acc_next        = '0;
                        cnt_next        = '0;
                        res_valid       = 1'b1;
                        res.kind        = RK_FIELD;
                        res.field_value = v_acc;
                    end
                end
                PH_FIX64, PH_FIX32: begin
                    acc_next = f_acc;
                    cnt_next = f_cnt;
                    if (f_cnt >= ((phase_reg == PH_FIX64) ? FIX64_BYTES : FIX32_BYTES)) begin
                        phase_next      = PH_TAG;
                        acc_next        = '0;
                        cnt_next        = '0;
                        res_valid       = 1'b1;
                        res.kind        = RK_FIELD;
                        res.field_value = f_acc;
                    end
                end
                PH_LEN: begin
                    acc_next = v_acc;
                    cnt_next = v_cnt;
                    if (v_over) begin
                        phase_next     = PH_DRAIN;
                        res_valid      = 1'b1;
                        res            = '0;
                        res.kind       = RK_ERROR;
                        res.error_code = ERR_VARINT;
                    end else if (v_done) begin
                        pstart_next = OFFSET_BITS'(pos_next);
                        if (v_acc == '0) begin
                            // empty payload completes on the length byte
                            phase_next         = PH_TAG;
                            acc_next           = '0;
                            cnt_next           = '0;
                            res_valid          = 1'b1;
                            res.kind           = RK_FIELD;
                            res.payload_offset = OFFSET_BITS'(pos_next);
                        end else begin
                            rem_next   = v_acc;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    rem_next = rem_reg - 1'b1;
                    if (rem_reg == VALUE_BITS'(1)) begin
                        phase_next         = PH_TAG;
                        acc_next           = '0;
                        cnt_next           = '0;
                        res_valid          = 1'b1;
                        res.kind           = RK_FIELD;
                        res.field_value    = acc_reg;
                        res.payload_offset = pstart_reg;
                    end
                end
                default: res_valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_TAG;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            fnum_reg   <= '0;
            wtype_reg  <= '0;
            rem_reg    <= '0;
            pos_reg    <= '0;
            pstart_reg <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            fnum_reg   <= fnum_next;
            wtype_reg  <= wtype_next;
            rem_reg    <= rem_next;
            pos_reg    <= pos_next;
            pstart_reg <= pstart_next;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= VARINT_MAX_BYTES)
        else $error("varint byte count beyond limit");

    a_payload_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> rem_reg != '0)
        else $error("payload phase with nothing left");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item_kind |=> phase_reg == PH_TAG && cnt_reg == '0 && pos_reg == '0)
        else $error("end marker did not clear state");

endmodule

// ----- design/protobuf_field_parser_core.sv -----
// Top level of the protobuf field parser: input stage, decoder, result register.
//
// Streams one buffer byte per request on the s_ channel (s_tuser = 1 marks
// the end of a buffer, with no byte). Each field of the protocol buffers wire
// format is decoded from its tag and value; one result request leaves on the
// m_ channel when a field completes, at a clean end of buffer, or on an
// error. After an error, bytes are dropped until the end marker, which
// then gives no result. Every end marker starts a new buffer at position 0.
// A byte accepted into the input stage is decoded there by the decoder logic,
// and its result is written to the result register when the stage advances.
// Throughput: one byte per cycle while m_tready does not stall the result;
// the decoder updates its state once per byte with combinational logic
// (a 64-bit merge shifter and one 64-bit decrement and compare).
// Reset (aresetn low at a clock edge) clears all parse state and both stages.
// When m_tready is low, the result is held and the input stage keeps one
// more byte; s_tready drops once both are full.
module protobuf_field_parser_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,  // [7:0] in_byte
    input  logic [0:0]                       s_tuser,  // [0] item_kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] field_number, [34:32] wire_type, [98:35] field_value,
    // [130:99] payload_offset, [132:131] error_code, [135:133] zero
    output logic [pbfp_pkg::M_TDATA_BITS-1:0] m_tdata,
    output logic [1:0]                       m_tuser   // [1:0] result_kind
);
    import pbfp_pkg::*;

    logic         in_valid_reg;
    logic         in_kind_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    pbfp_result_t out_reg;
    logic         advance;
    logic         res_valid;
    pbfp_result_t res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    pbfp_decoder u_decoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .item_kind (in_kind_reg),
        .in_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance && res_valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg <= s_tuser[0];
            in_byte_reg <= s_tdata;
        end
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {3'b000, out_reg.error_code, out_reg.payload_offset,
                       out_reg.field_value, out_reg.wire_type, out_reg.field_number};

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_tready |=> in_valid_reg)
        else $error("input stage lost a byte under stall");

    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg)
        else $error("input blocked without a stalled result");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == RK_FIELD || m_tuser == RK_END || m_tuser == RK_ERROR)
        else $error("bad result kind");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != RK_ERROR |-> m_tdata[132:131] == ERR_VARINT)
        else $error("error code set on non-error result");

endmodule
